@@ src/mrb_pkg.sv @@
`default_nettype none
package mrb_pkg;

    localparam int MAX_COLS   = 256;
    localparam int MAX_ROWS   = 1024;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int DEPTH_W    = $clog2(MAX_COLS + 1);
    localparam int NCOL_W     = 9;
    localparam int HGT_W      = $clog2(MAX_ROWS + 1);
    localparam int AREA_W     = 19;
    localparam int PROD_W     = HGT_W + DEPTH_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [NCOL_W-1:0] NUM_COLS_RST = NCOL_W'(MAX_COLS);
    localparam logic [AREA_W-1:0] AREA_MAX     = {AREA_W{1'b1}};

    typedef struct packed {
        logic             filled;
        logic             last;
        logic             eor;
        logic [COL_W-1:0] col;
    } t_op;

    typedef struct packed {
        logic [COL_W-1:0] idx;
        logic [HGT_W-1:0] h;
    } t_ent;

endpackage
`default_nettype wire

@@ src/mrb_front.sv @@
`default_nettype none
module mrb_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_cell_req,
    input  wire logic                         i_last_cell,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [mrb_pkg::NCOL_W-1:0]   i_cfg_num_cols,
    input  wire logic                         i_full,
    output logic                              o_push,
    output mrb_pkg::t_op                      o_op
);
    import mrb_pkg::*;

    logic [NCOL_W-1:0] r_num_cols;
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic [NCOL_W-1:0] eff_cols;
    logic [NCOL_W-1:0] col_next;
    logic              eor;

    always_comb begin
        if (r_num_cols == '0) begin
            eff_cols = NCOL_W'(1);
        end else if (r_num_cols > NCOL_W'(MAX_COLS)) begin
            eff_cols = NCOL_W'(MAX_COLS);
        end else begin
            eff_cols = r_num_cols;
        end
    end

    assign col_next = NCOL_W'(r_col) + NCOL_W'(1);
    assign eor      = (col_next >= eff_cols) || i_last_cell;
    assign n_col    = eor ? '0 : col_next[COL_W-1:0];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_full;
    assign o_push      = i_in_valid && !i_full;

    always_comb begin
        o_op.filled = i_cell_req;
        o_op.last   = i_last_cell;
        o_op.eor    = eor;
        o_op.col    = r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= NUM_COLS_RST;
            r_col      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_num_cols <= i_cfg_num_cols;
            end
            if (o_push) begin
                r_col <= n_col;
            end
        end
    end

endmodule
`default_nettype wire

@@ src/mrb_fifo.sv @@
`default_nettype none
module mrb_fifo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire mrb_pkg::t_op i_data,
    input  wire logic         i_pop,
    output logic              o_full,
    output logic              o_empty,
    output mrb_pkg::t_op      o_data
);
    import mrb_pkg::*;

    t_op               r_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wptr;
    logic [FPTR_W-1:0] r_rptr;
    logic [FCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == FCNT_W'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + FPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + FPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + FCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - FCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ src/mrb_back.sv @@
`default_nettype none
module mrb_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_empty,
    input  wire mrb_pkg::t_op                i_op,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [mrb_pkg::AREA_W-1:0]       o_rect_area
);
    import mrb_pkg::*;

    localparam logic [2:0] B_IDLE   = 3'd0;
    localparam logic [2:0] B_HGT    = 3'd1;
    localparam logic [2:0] B_CMP    = 3'd2;
    localparam logic [2:0] B_FLUSH  = 3'd3;
    localparam logic [2:0] B_REFILL = 3'd4;
    localparam logic [2:0] B_EMIT   = 3'd5;

    localparam logic [HGT_W-1:0] ROWS_CAP = HGT_W'(MAX_ROWS);

    logic [2:0]          r_state;
    logic [2:0]          r_ret;
    t_op                 r_cur;
    logic [HGT_W-1:0]    r_nh;
    logic [DEPTH_W-1:0]  r_depth;
    t_ent                r_top;
    t_ent                r_sec;
    t_ent                r_srd;
    t_ent                stk [MAX_COLS];
    logic [HGT_W-1:0]    hgt [MAX_COLS];
    logic [HGT_W-1:0]    r_hrd;
    logic                r_hv;
    logic [MAX_COLS-1:0] r_hvld;
    logic [PROD_W-1:0]   r_prod;
    logic                r_prod_vld;
    logic [AREA_W-1:0]   r_best;
    logic                r_out_vld;
    logic [AREA_W-1:0]   r_out_area;

    logic [HGT_W-1:0]    h_cur;
    logic [HGT_W-1:0]    nh;
    logic [DEPTH_W-1:0]  edge_col;
    logic [DEPTH_W-1:0]  wid;
    logic [AREA_W-1:0]   area_sat;
    logic [COL_W-1:0]    srd_addr;
    logic                do_pop_cmp;
    logic                do_pop_flush;
    logic                st_pop;
    logic                st_push;
    logic                out_load;
    t_ent                push_ent;

    assign h_cur = r_hv ? r_hrd : '0;

    always_comb begin
        if (!r_cur.filled) begin
            nh = '0;
        end else if (h_cur >= ROWS_CAP) begin
            nh = ROWS_CAP;
        end else begin
            nh = h_cur + HGT_W'(1);
        end
    end

    assign do_pop_cmp   = (r_state == B_CMP) && (r_depth != '0) && (r_top.h > r_nh);
    assign do_pop_flush = (r_state == B_FLUSH) && (r_depth != '0);
    assign st_pop       = do_pop_cmp || do_pop_flush;
    assign st_push      = (r_state == B_CMP) && !do_pop_cmp;
    assign push_ent.idx = r_cur.col;
    assign push_ent.h   = r_nh;

    assign edge_col = (r_state == B_FLUSH) ? DEPTH_W'(r_cur.col) + DEPTH_W'(1)
                                           : DEPTH_W'(r_cur.col);
    assign wid      = (r_depth >= DEPTH_W'(2))
                    ? edge_col - DEPTH_W'(r_sec.idx) - DEPTH_W'(1)
                    : edge_col;
    assign srd_addr = COL_W'(r_depth - DEPTH_W'(3));
    assign area_sat = (r_prod > PROD_W'(AREA_MAX)) ? AREA_MAX : r_prod[AREA_W-1:0];

    assign o_pop       = (r_state == B_IDLE) && !i_empty;
    assign out_load    = (r_state == B_EMIT) && (!r_out_vld || !i_out_stall);
    assign o_out_valid = r_out_vld;
    assign o_rect_area = r_out_area;

    // stack and height stores
    always_ff @(posedge i_clk) begin
        if (st_push) begin
            stk[r_depth[COL_W-1:0]] <= push_ent;
        end
        r_srd <= stk[srd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_HGT) begin
            hgt[r_cur.col] <= nh;
        end
        r_hrd <= hgt[i_op.col];
        r_hv  <= r_hvld[i_op.col];
    end

    always_ff @(posedge i_clk) begin
        if (st_pop) begin
            r_prod <= PROD_W'(r_top.h) * PROD_W'(wid);
        end
        if (r_state == B_HGT) begin
            r_nh <= nh;
        end
        if (o_pop) begin
            r_cur <= i_op;
        end
        if (st_push) begin
            r_top <= push_ent;
            r_sec <= r_top;
        end else if (st_pop) begin
            r_top <= r_sec;
        end else if (r_state == B_REFILL) begin
            r_sec <= r_srd;
        end
        if (out_load) begin
            r_out_area <= r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_ret      <= B_IDLE;
            r_depth    <= '0;
            r_hvld     <= '0;
            r_prod_vld <= 1'b0;
            r_best     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_prod_vld <= st_pop;
            if (out_load) begin
                r_best <= '0;
            end else if (r_prod_vld && (area_sat > r_best)) begin
                r_best <= area_sat;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (st_push) begin
                r_depth <= r_depth + DEPTH_W'(1);
            end else if (st_pop) begin
                r_depth <= r_depth - DEPTH_W'(1);
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_state <= B_HGT;
                    end
                end
                B_HGT: begin
                    r_hvld[r_cur.col] <= 1'b1;
                    r_state <= B_CMP;
                end
                B_CMP: begin
                    if (do_pop_cmp) begin
                        r_ret   <= B_CMP;
                        r_state <= B_REFILL;
                    end else if (r_cur.eor) begin
                        r_state <= B_FLUSH;
                    end else begin
                        r_state <= B_IDLE;
                    end
                end
                B_FLUSH: begin
                    if (do_pop_flush) begin
                        r_ret   <= B_FLUSH;
                        r_state <= B_REFILL;
                    end else if (r_cur.last) begin
                        r_state <= B_EMIT;
                    end else begin
                        r_state <= B_IDLE;
                    end
                end
                B_REFILL: begin
                    r_state <= r_ret;
                end
                B_EMIT: begin
                    if (out_load) begin
                        r_hvld  <= '0;
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(MAX_COLS))
        else $error("stack depth beyond column count");

    a_emit_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EMIT) |-> (r_depth == '0))
        else $error("result emitted with stack not flushed");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_best == '0) && (r_hvld == '0) && o_out_valid)
        else $error("matrix state not cleared after result");

    a_stack_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth >= DEPTH_W'(2)) && (r_state != B_REFILL) |-> (r_sec.idx < r_top.idx))
        else $error("stack indices out of order");

    a_top_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth != '0) && (r_state == B_CMP) |-> (r_top.idx < r_cur.col))
        else $error("stack top not left of current column");

endmodule
`default_nettype wire

@@ src/max_rectangle_binary_matrix.sv @@
// channel  direction  handshake                   word
// in       input      i_in_valid / o_in_stall     i_cell_req, i_last_cell
// out      output     o_out_valid / i_out_stall   o_rect_area
// cfg      input      i_cfg_valid / o_cfg_ready   i_cfg_num_cols
//
// a cell goes through the back sequencer states idle, height and compare, each stack pop adds a refill step,
// a row end adds a flush step, the last cell adds an emit step to hand over the result
// the stack store with registered read sets the refill step after each pop
// synchronous reset clears control state and the height valid bits, no clearing pass
// a 4-word queue parts the front from the back, an output register holds the result
`default_nettype none
module max_rectangle_binary_matrix (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_cell_req,
    input  wire logic                        i_last_cell,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [mrb_pkg::AREA_W-1:0]       o_rect_area,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [mrb_pkg::NCOL_W-1:0]  i_cfg_num_cols
);
    import mrb_pkg::*;

    logic full;
    logic empty;
    logic push;
    logic pop;
    t_op  op_in;
    t_op  op_out;

    mrb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cell_req     (i_cell_req),
        .i_last_cell    (i_last_cell),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_num_cols (i_cfg_num_cols),
        .i_full         (full),
        .o_push         (push),
        .o_op           (op_in)
    );

    mrb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (op_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (op_out)
    );

    mrb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_op        (op_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rect_area (o_rect_area)
    );

endmodule
`default_nettype wire
